@@ design/assert_macros.svh @@
// Assertion macros shared by checker files.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ design/bllm_pkg.sv @@
// Package for the bounded linked list manager: sizes, action codes, states.
// No dependencies.
package bllm_pkg;
	localparam int CAPACITY = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W = $clog2(CAPACITY + 1);
	localparam int SLOT_W = $clog2(CAPACITY);
	localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(CAPACITY);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [DATA_WIDTH-1:0] val_t;

	typedef enum logic [2:0] {
		ACT_APPEND = 3'd0,
		ACT_PUSH_HEAD = 3'd1,
		ACT_INS_AFTER = 3'd2,
		ACT_REMOVE = 3'd3,
		ACT_CLEAR = 3'd4,
		ACT_READ = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_WAIT,
		S_LINK,
		S_OUT
	} state_t;

	// Memory port request from the sequencer.
	typedef struct packed {
		logic we_val;
		logic we_link;
		logic [SLOT_W-1:0] waddr;
		val_t wval;
		idx_t wlink;
		logic [SLOT_W-1:0] lwaddr;
		logic [SLOT_W-1:0] raddr;
	} mem_req_t;

	function automatic logic is_node(idx_t i);
		return i < IDX_W'(CAPACITY);
	endfunction
endpackage

@@ design/bounded_linked_list_manager.sv @@
// channel | handshake            | fields
// in      | in_valid, in_ready   | action, item_value, match_value
// out     | out_valid, out_ready | out_value, last_flag, status_code
// Head ops, clear, empty-list, unused codes: result word in the cycle after accept.
// A walk visits each node in S_WALK (address), then S_WAIT (compare); append and
// insert-after then write the new node in S_LINK, and read out waits in S_OUT
// until each word is taken. Worst case: read of CAPACITY nodes.
// arst_n clears head, used map and sequencer; node memories are not cleared.
// The sequencer holds on out_ready low; input is not ready while a word is pending.
// Depends on bllm_pkg and bllm_node_mem.
module bounded_linked_list_manager (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] action,
	input logic signed [31:0] item_value,
	input logic signed [31:0] match_value,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] out_value,
	output logic last_flag,
	output logic [1:0] status_code
);
	import bllm_pkg::*;

	state_t state_q, state_d;
	logic [CAPACITY-1:0] used_q, used_d;
	idx_t head_q, head_d;
	logic [2:0] act_q;
	val_t ival_q, mval_q;
	idx_t cur_q, cur_d, prev_q, prev_d, slot_q;
	logic [IDX_W:0] steps_q, steps_d;
	logic ov_q, ov_d, ol_q, ol_d;
	logic [1:0] os_q, os_d;
	logic signed [31:0] oval_q, oval_d;
	mem_req_t req;
	val_t rd_val;
	idx_t rd_link;
	idx_t free_idx;
	logic accept;

	bllm_node_mem u_mem (.clk(clk), .req(req), .rd_val(rd_val), .rd_link(rd_link));

	always_comb begin
		free_idx = NULL_IDX;
		for (int i = CAPACITY - 1; i >= 0; i--)
			if (!used_q[i])
				free_idx = IDX_W'(i);
	end

	assign in_ready = (state_q == S_IDLE) && !ov_q;
	assign accept = in_valid && in_ready;
	assign out_valid = ov_q;
	assign out_value = oval_q;
	assign last_flag = ol_q;
	assign status_code = os_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			head_q <= NULL_IDX;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q <= used_d;
			head_q <= head_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			ival_q <= val_t'(item_value);
			mval_q <= val_t'(match_value);
			slot_q <= free_idx;
		end
		cur_q <= cur_d;
		prev_q <= prev_d;
		steps_q <= steps_d;
		ol_q <= ol_d;
		os_q <= os_d;
		oval_q <= oval_d;
	end

	always_comb begin
		logic [SLOT_W-1:0] cs;
		logic hit;
		val_t key;
		state_d = state_q;
		used_d = used_q;
		head_d = head_q;
		cur_d = cur_q;
		prev_d = prev_q;
		steps_d = steps_q;
		ov_d = ov_q;
		ol_d = ol_q;
		os_d = os_q;
		oval_d = oval_q;
		cs = cur_q[SLOT_W-1:0];
		req = '0;
		req.raddr = cs;
		req.waddr = slot_q[SLOT_W-1:0];
		req.wval = ival_q;
		key = (act_q == ACT_INS_AFTER) ? mval_q : ival_q;
		hit = (rd_val == key);
		if (ov_q && out_ready)
			ov_d = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ol_d = 1'b1;
					os_d = ST_OK;
					oval_d = '0;
					cur_d = head_q;
					prev_d = NULL_IDX;
					steps_d = '0;
					case (action)
						ACT_APPEND, ACT_PUSH_HEAD, ACT_INS_AFTER: begin
							if (!is_node(free_idx)) begin
								os_d = ST_FULL;
								ov_d = 1'b1;
							end else if (action == ACT_INS_AFTER) begin
								if (is_node(head_q))
									state_d = S_WALK;
								else begin
									os_d = ST_NOT_FOUND;
									ov_d = 1'b1;
								end
							end else if (action == ACT_PUSH_HEAD || !is_node(head_q)) begin
								req.we_val = 1'b1;
								req.waddr = free_idx[SLOT_W-1:0];
								req.wval = val_t'(item_value);
								req.we_link = 1'b1;
								req.lwaddr = free_idx[SLOT_W-1:0];
								req.wlink = head_q;
								head_d = free_idx;
								used_d[free_idx[SLOT_W-1:0]] = 1'b1;
								ov_d = 1'b1;
							end else
								state_d = S_WALK;
						end
						ACT_REMOVE: begin
							if (is_node(head_q))
								state_d = S_WALK;
							else begin
								os_d = ST_NOT_FOUND;
								ov_d = 1'b1;
							end
						end
						ACT_CLEAR: begin
							used_d = '0;
							head_d = NULL_IDX;
							ov_d = 1'b1;
						end
						ACT_READ: begin
							if (is_node(head_q))
								state_d = S_WALK;
							else begin
								os_d = ST_EMPTY;
								ov_d = 1'b1;
							end
						end
						default: ov_d = 1'b1;
					endcase
				end
			end
			S_WALK: begin
				// address cur_q is presented; data arrives next cycle
				state_d = S_WAIT;
			end
			S_WAIT: begin
				state_d = S_WALK;
				steps_d = steps_q + 1'b1;
				case (act_q)
					ACT_APPEND: begin
						if (!is_node(rd_link) || steps_q == (IDX_W+1)'(CAPACITY)) begin
							req.we_link = 1'b1;
							req.lwaddr = cs;
							req.wlink = slot_q;
							state_d = S_LINK;
						end else
							cur_d = rd_link;
					end
					ACT_READ: begin
						oval_d = 32'(signed'(rd_val));
						os_d = ST_OK;
						ol_d = !is_node(rd_link) || steps_q == (IDX_W+1)'(CAPACITY - 1);
						ov_d = 1'b1;
						cur_d = rd_link;
						state_d = S_OUT;
					end
					default: begin
						if (hit) begin
							if (act_q == ACT_INS_AFTER) begin
								req.we_link = 1'b1;
								req.lwaddr = cs;
								req.wlink = slot_q;
								prev_d = rd_link;
								state_d = S_LINK;
							end else begin
								if (is_node(prev_q)) begin
									req.we_link = 1'b1;
									req.lwaddr = prev_q[SLOT_W-1:0];
									req.wlink = rd_link;
								end else
									head_d = rd_link;
								used_d[cs] = 1'b0;
								ov_d = 1'b1;
								state_d = S_IDLE;
							end
						end else if (!is_node(rd_link) ||
							steps_q == (IDX_W+1)'(CAPACITY - 1)) begin
							os_d = ST_NOT_FOUND;
							ov_d = 1'b1;
							state_d = S_IDLE;
						end else begin
							prev_d = cur_q;
							cur_d = rd_link;
						end
					end
				endcase
			end
			S_LINK: begin
				// write the new node: append gets null, insert-after the old successor
				req.we_val = 1'b1;
				req.we_link = 1'b1;
				req.lwaddr = slot_q[SLOT_W-1:0];
				req.wlink = (act_q == ACT_APPEND) ? NULL_IDX : prev_q;
				used_d[slot_q[SLOT_W-1:0]] = 1'b1;
				ov_d = 1'b1;
				os_d = ST_OK;
				state_d = S_IDLE;
			end
			S_OUT: begin
				// hold the element until taken, then advance
				if (out_ready) begin
					state_d = ol_q ? S_IDLE : S_WALK;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

@@ design/bllm_node_mem.sv @@
// Node store: value and link memories, one write each and one shared read address.
// Depends on bllm_pkg.
module bllm_node_mem (
	input logic clk,
	input bllm_pkg::mem_req_t req,
	output bllm_pkg::val_t rd_val,
	output bllm_pkg::idx_t rd_link
);
	import bllm_pkg::*;
	val_t vals_q [CAPACITY];
	idx_t links_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we_val)
			vals_q[req.waddr] <= req.wval;
		if (req.we_link)
			links_q[req.lwaddr] <= req.wlink;
		rd_val <= vals_q[req.raddr];
		rd_link <= links_q[req.raddr];
	end
endmodule

@@ design/bllm_checker.sv @@
// Port-level checker for bounded_linked_list_manager, bound to the top level.
// Depends on assert_macros.svh and bllm_pkg.
`include "assert_macros.svh"
module bllm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [31:0] out_value,
	input logic last_flag,
	input logic [1:0] status_code
);
	import bllm_pkg::*;

	`CHK_IMPL(a_no_in_while_out, clk, arst_n, out_valid, !in_ready, "ready with word pending")
	`CHK_IMPL(a_status_last, clk, arst_n, out_valid && status_code != ST_OK, last_flag && out_value == 32'sd0, "status word not final")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_value), "word dropped")
	`CHK_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "accepted twice")
endmodule

bind bounded_linked_list_manager bllm_checker u_bllm_checker (.*);

@@ dv/tb_bounded_linked_list_manager.sv @@
// Testbench for bounded_linked_list_manager: random and directed list commands,
// checked against an in-bench list model. Depends on bllm_pkg and the block RTL.
module tb_bounded_linked_list_manager;
	import bllm_pkg::*;

	localparam int NODES = 16;

	typedef struct {
		logic [2:0] act;
		logic [31:0] ival;
		logic [31:0] mval;
	} cmd_t;

	typedef struct {
		logic [31:0] value;
		logic last;
		logic [1:0] status;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] action = '0;
	logic signed [31:0] item_value = '0;
	logic signed [31:0] match_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] out_value;
	logic last_flag;
	logic [1:0] status_code;

	cmd_t pending_cmds[$];
	word_t expected_words[$];
	int mismatch_count = 0;
	int words_checked = 0;
	int cmds_sent = 0;
	int tx_issued = 0;
	int tx_wait = 0;
	bit tx_busy = 1'b0;
	int rx_wait = 0;
	int rx_seen = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// list shadow
	logic [31:0] shadow_val[NODES];
	int shadow_link[NODES];
	bit shadow_used[NODES];
	int shadow_head = NODES;

	bounded_linked_list_manager u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .item_value(item_value), .match_value(match_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_value(out_value), .last_flag(last_flag), .status_code(status_code)
	);

	always #2 clk = ~clk;

	function automatic void push_status(logic [1:0] st);
		word_t w;
		w.value = '0;
		w.last = 1'b1;
		w.status = st;
		expected_words.push_back(w);
	endfunction

	function automatic int find_node(logic [31:0] v, output int prev);
		int cur;
		int steps;
		cur = shadow_head;
		prev = NODES;
		steps = 0;
		while (cur < NODES && steps < NODES) begin
			if (shadow_val[cur] == v)
				return cur;
			prev = cur;
			cur = shadow_link[cur];
			steps++;
		end
		return NODES;
	endfunction

	function automatic void predict_list_cmd(cmd_t c);
		int slot, cur, prev, n;
		word_t w;
		slot = NODES;
		case (c.act)
			ACT_APPEND, ACT_PUSH_HEAD, ACT_INS_AFTER: begin
				for (int i = NODES - 1; i >= 0; i--)
					if (!shadow_used[i])
						slot = i;
				if (slot == NODES) begin
					push_status(ST_FULL);
					return;
				end
				if (c.act == ACT_INS_AFTER) begin
					cur = find_node(c.mval, prev);
					if (cur == NODES) begin
						push_status(ST_NOT_FOUND);
						return;
					end
					shadow_link[slot] = shadow_link[cur];
					shadow_link[cur] = slot;
				end else if (c.act == ACT_PUSH_HEAD || shadow_head == NODES) begin
					shadow_link[slot] = shadow_head;
					shadow_head = slot;
				end else begin
					cur = shadow_head;
					while (shadow_link[cur] < NODES)
						cur = shadow_link[cur];
					shadow_link[slot] = NODES;
					shadow_link[cur] = slot;
				end
				shadow_val[slot] = c.ival;
				shadow_used[slot] = 1'b1;
				push_status(ST_OK);
			end
			ACT_REMOVE: begin
				cur = find_node(c.ival, prev);
				if (cur == NODES) begin
					push_status(ST_NOT_FOUND);
					return;
				end
				if (prev < NODES)
					shadow_link[prev] = shadow_link[cur];
				else
					shadow_head = shadow_link[cur];
				shadow_used[cur] = 1'b0;
				push_status(ST_OK);
			end
			ACT_CLEAR: begin
				for (int i = 0; i < NODES; i++)
					shadow_used[i] = 1'b0;
				shadow_head = NODES;
				push_status(ST_OK);
			end
			ACT_READ: begin
				if (shadow_head == NODES) begin
					push_status(ST_EMPTY);
					return;
				end
				cur = shadow_head;
				n = 0;
				while (cur < NODES && n < NODES) begin
					w.value = shadow_val[cur];
					w.status = ST_OK;
					cur = shadow_link[cur];
					n++;
					w.last = !(cur < NODES && n < NODES);
					expected_words.push_back(w);
				end
			end
			default: push_status(ST_OK);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH word %0d %s: got %h want %h", words_checked, what, got, want);
		mismatch_count++;
	endtask

	function automatic void queue_cmd(logic [2:0] a, logic [31:0] iv, logic [31:0] mv);
		cmd_t c;
		c.act = a;
		c.ival = iv;
		c.mval = mv;
		pending_cmds.push_back(c);
	endfunction

	// Driver: fed from pending_cmds, random gap before each word.
	always @(negedge clk) begin
		cmd_t c;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_busy = 1'b0;
			tx_wait = $urandom_range(0, 6);
		end else begin
			if (tx_busy && cmds_sent == tx_issued) begin
				tx_busy = 1'b0;
				tx_wait = $urandom_range(0, 6);
			end
			if (!tx_busy) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					c = pending_cmds.pop_front();
					action <= c.act;
					item_value <= c.ival;
					match_value <= c.mval;
					in_valid <= 1'b1;
					tx_busy = 1'b1;
					tx_issued++;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Input monitor: predict on every accepted command.
	always @(posedge clk) begin
		cmd_t c;
		if (arst_n && in_valid && in_ready) begin
			c.act = action;
			c.ival = item_value;
			c.mval = match_value;
			predict_list_cmd(c);
			cmds_sent++;
		end
	end

	// Long receiver hold-off once the run is under way.
	always @(negedge clk) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && cmds_sent >= 40) begin
			hold_left <= 200;
			hold_done <= 1'b1;
		end
	end

	// Receiver ready: random wait before each word.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = $urandom_range(0, 6);
			rx_seen = 0;
		end else begin
			if (words_checked != rx_seen) begin
				rx_seen = words_checked;
				rx_wait = $urandom_range(0, 6);
			end
			if (hold_left > 0)
				out_ready <= 1'b0;
			else if (rx_wait > 0) begin
				out_ready <= 1'b0;
				if (out_valid)
					rx_wait--;
			end else
				out_ready <= 1'b1;
		end
	end

	// Monitor
	always @(posedge clk) begin
		word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected", out_value, '0);
			end else begin
				w = expected_words.pop_front();
				if (out_value !== w.value)
					report_mismatch("out_value", out_value, w.value);
				if (last_flag !== w.last)
					report_mismatch("last_flag", last_flag, w.last);
				if (status_code !== w.status)
					report_mismatch("status_code", status_code, w.status);
			end
			words_checked++;
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			default: return $urandom_range(0, 7);
		endcase
	endfunction

	initial begin : stimulus
		logic [2:0] a;
		for (int i = 0; i < NODES; i++) begin
			shadow_used[i] = 1'b0;
			shadow_link[i] = NODES;
			shadow_val[i] = '0;
		end
		// directed: empty-list cases, extremes, full pool, unused codes
		queue_cmd(ACT_READ, 0, 0);
		queue_cmd(ACT_REMOVE, 5, 0);
		queue_cmd(ACT_INS_AFTER, 1, 2);
		queue_cmd(ACT_APPEND, 32'h8000_0000, 0);
		queue_cmd(ACT_PUSH_HEAD, 32'h7fff_ffff, 0);
		queue_cmd(ACT_INS_AFTER, 32'hffff_ffff, 32'h7fff_ffff);
		queue_cmd(ACT_READ, 0, 32'hffff_ffff);
		queue_cmd(ACT_REMOVE, 32'h7fff_ffff, 0);
		queue_cmd(3'd6, 32'hffff_ffff, 32'hffff_ffff);
		queue_cmd(3'd7, 0, 0);
		for (int i = 0; i < 17; i++)
			queue_cmd(ACT_APPEND, i, 0);
		queue_cmd(ACT_READ, 0, 0);
		queue_cmd(ACT_CLEAR, 0, 0);
		queue_cmd(ACT_READ, 0, 0);
		// random: half inserts, values often small so matches hit
		for (int i = 0; i < 130; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: a = ACT_APPEND;
				4, 5, 6: a = ACT_PUSH_HEAD;
				7, 8, 9: a = ACT_INS_AFTER;
				10, 11, 12, 13: a = ACT_REMOVE;
				14, 15, 16: a = ACT_READ;
				17: a = ACT_CLEAR;
				default: a = 3'($urandom_range(6, 7));
			endcase
			queue_cmd(a, pick_value(), pick_value());
		end
		queue_cmd(ACT_READ, 0, 0);
		#48 arst_n = 1'b1;
		wait (pending_cmds.size() == 0 && cmds_sent == tx_issued &&
			expected_words.size() == 0);
		repeat (60) @(posedge clk);
		$display("Sent %0d commands, checked %0d result words", cmds_sent, words_checked);
		$display("Covered empty, full, no-match, clear, extremes and a long receiver stall");
		if (mismatch_count == 0 && expected_words.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
